### sv/ubml_pkg.sv
// Shared types and constants for the batch memory loader.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ubml_pkg;

  localparam logic [7:0] CMD_BATCH = 8'h42;
  localparam int unsigned WORDS_PER_BATCH_DEF = 16;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TX    = 1'b1;

  // back-end emission steps: one write, then four checksum bytes
  typedef enum logic [2:0] {
    STEP_WRITE = 3'd0,
    STEP_TX0   = 3'd1,
    STEP_TX1   = 3'd2,
    STEP_TX2   = 3'd3,
    STEP_TX3   = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // one completed data word, as handed from front to back
  typedef struct packed {
    logic        fin;
    logic [31:0] addr;
    logic [31:0] word;
    logic [31:0] sum;
  } cmd_t;

endpackage

### sv/ubml_front.sv
// Front end: accepts serial bytes, tracks command/address/data phases and
// assembles words. Pushes one command per completed data word. Uses ubml_pkg.
module ubml_front #(
  parameter int unsigned WORDS_PER_BATCH = ubml_pkg::WORDS_PER_BATCH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            cmd_push,
  output ubml_pkg::cmd_t  cmd
);

  localparam int unsigned WIDX_W = (WORDS_PER_BATCH > 1) ? $clog2(WORDS_PER_BATCH) : 1;
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS_PER_BATCH - 1);

  ubml_pkg::phase_t phase, phase_next;
  logic [1:0]        byte_index, byte_index_next;
  logic [WIDX_W-1:0] word_index, word_index_next;
  logic [31:0]       assembly_shift, assembly_shift_next;
  logic [31:0]       write_pointer, write_pointer_next;
  logic [31:0]       xor_sum, xor_sum_next;

  logic [31:0] shifted;
  logic        word_done;
  logic        batch_done;
  logic [31:0] sum_new;

  assign shifted    = {assembly_shift[23:0], rx_byte};
  assign word_done  = (byte_index == 2'd3);
  assign batch_done = (word_index == WIDX_LAST);
  assign sum_new    = xor_sum ^ shifted;

  // phase transitions
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        ubml_pkg::PH_ADDR: begin
          if (word_done) phase_next = ubml_pkg::PH_DATA;
        end
        ubml_pkg::PH_DATA: begin
          if (word_done && batch_done) phase_next = ubml_pkg::PH_IDLE;
        end
        default: begin
          phase_next = (rx_byte == ubml_pkg::CMD_BATCH) ? ubml_pkg::PH_ADDR
                                                        : ubml_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // datapath and queue push
  always_comb begin
    byte_index_next     = byte_index;
    word_index_next     = word_index;
    assembly_shift_next = assembly_shift;
    write_pointer_next  = write_pointer;
    xor_sum_next        = xor_sum;
    cmd_push            = 1'b0;
    cmd.fin             = batch_done;
    cmd.addr            = write_pointer;
    cmd.word            = shifted;
    cmd.sum             = sum_new;
    if (accept) begin
      unique case (phase) inside
        ubml_pkg::PH_ADDR, ubml_pkg::PH_DATA: begin
          if (!word_done) begin
            byte_index_next     = byte_index + 2'd1;
            assembly_shift_next = shifted;
          end else begin
            byte_index_next     = 2'd0;
            assembly_shift_next = 32'd0;
            if (phase == ubml_pkg::PH_ADDR) begin
              write_pointer_next = shifted;
              word_index_next    = '0;
              xor_sum_next       = 32'd0;
            end else begin
              cmd_push           = 1'b1;
              xor_sum_next       = sum_new;
              write_pointer_next = write_pointer + 32'd4;
              word_index_next    = batch_done ? '0 : word_index + 1'b1;
            end
          end
        end
        default: begin
          if (rx_byte == ubml_pkg::CMD_BATCH) begin
            byte_index_next     = 2'd0;
            word_index_next     = '0;
            assembly_shift_next = 32'd0;
            xor_sum_next        = 32'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ubml_pkg::PH_IDLE;
      byte_index     <= 2'd0;
      word_index     <= '0;
      assembly_shift <= 32'd0;
      write_pointer  <= 32'd0;
      xor_sum        <= 32'd0;
    end else begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      word_index     <= word_index_next;
      assembly_shift <= assembly_shift_next;
      write_pointer  <= write_pointer_next;
      xor_sum        <= xor_sum_next;
    end
  end

endmodule

### sv/ubml_queue.sv
// Short command queue between front and back.
// Holds ubml_pkg::cmd_t entries; depth from ubml_pkg::QUEUE_DEPTH.
module ubml_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ubml_pkg::cmd_t  push_data,
  input  logic            pop,
  output ubml_pkg::cmd_t  head,
  output logic            q_empty,
  output logic            q_full
);

  ubml_pkg::cmd_t mem [ubml_pkg::QUEUE_DEPTH];
  logic [ubml_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ubml_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push, do_pop;

  assign q_empty = (count == '0);
  assign q_full  = (count == ubml_pkg::QUEUE_CNT_W'(ubml_pkg::QUEUE_DEPTH));
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/ubml_back.sv
// Back end: turns queued commands into results, one per cycle while pop is high,
// via an output register. A final word adds four checksum bytes. Uses ubml_pkg.
module ubml_back (
  input  logic            clk,
  input  logic            rst,
  input  ubml_pkg::cmd_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            out_valid,
  output logic            kind,
  output logic [31:0]     mem_address,
  output logic [31:0]     mem_word,
  output logic [7:0]      tx_data,
  output logic            last
);

  ubml_pkg::step_t step, step_next;
  logic       load;
  logic       gen;
  logic       out_valid_next;

  logic        r_kind;
  logic [31:0] r_addr;
  logic [31:0] r_word;
  logic [7:0]  r_tx;
  logic        r_last;

  assign load = !out_valid || pop;
  assign gen  = load && !q_empty;

  // result fields for the current step
  always_comb begin
    r_kind = ubml_pkg::KIND_TX;
    r_addr = 32'd0;
    r_word = 32'd0;
    r_tx   = 8'd0;
    r_last = 1'b0;
    unique case (step)
      ubml_pkg::STEP_WRITE: begin
        r_kind = ubml_pkg::KIND_WRITE;
        r_addr = head.addr;
        r_word = head.word;
        r_last = !head.fin;
      end
      ubml_pkg::STEP_TX0: r_tx = head.sum[31:24];
      ubml_pkg::STEP_TX1: r_tx = head.sum[23:16];
      ubml_pkg::STEP_TX2: r_tx = head.sum[15:8];
      ubml_pkg::STEP_TX3: begin
        r_tx   = head.sum[7:0];
        r_last = 1'b1;
      end
      default: r_tx = 8'd0;
    endcase
  end

  // step sequencing and queue retire
  always_comb begin
    q_pop          = 1'b0;
    step_next      = step;
    out_valid_next = load ? !q_empty : 1'b1;
    if (gen) begin
      // retire the entry after its last result
      q_pop = r_last;
      unique case (step)
        ubml_pkg::STEP_WRITE: begin
          step_next = head.fin ? ubml_pkg::STEP_TX0 : ubml_pkg::STEP_WRITE;
        end
        ubml_pkg::STEP_TX0: step_next = ubml_pkg::STEP_TX1;
        ubml_pkg::STEP_TX1: step_next = ubml_pkg::STEP_TX2;
        ubml_pkg::STEP_TX2: step_next = ubml_pkg::STEP_TX3;
        default:            step_next = ubml_pkg::STEP_WRITE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ubml_pkg::STEP_WRITE;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      kind        <= r_kind;
      mem_address <= r_addr;
      mem_word    <= r_word;
      tx_data     <= r_tx;
      last        <= r_last;
    end
  end

endmodule

### sv/uart_batch_memory_loader.sv
// Batch memory loader driven by received serial bytes.
// Input channel: rx_byte, taken when push is high and full is low. Command
// byte 0x42 starts a batch; four bytes of big-endian start address and then
// WORDS_PER_BATCH big-endian data words follow. Other bytes while idle drop.
// Result channel: a queue interface; while empty is low the oldest result is
// on kind/mem_address/mem_word/tx_data/last, and pop takes it.
// Each completed data word gives a memory write (kind 0); the last word of a
// batch gives the write plus four checksum bytes (kind 1), MSB first.
// Throughput: one byte per cycle in while full is low; results leave at one
// per cycle from an output register while pop is high. A completed word goes
// through a queue entry, then the output register, to the result ports.
// A four-entry command queue sits between the byte front end and the result
// back end; full rises only when that queue is full, i.e. when the receiver
// has held off popping for long enough. A final word occupies the back end
// for its write and then four checksum bytes.
// Reset clears phase, counters, write pointer, checksum, queue pointers and
// output valid flag; empty is high afterwards.
module uart_batch_memory_loader #(
  parameter int unsigned WORDS_PER_BATCH = ubml_pkg::WORDS_PER_BATCH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [31:0] mem_address,
  output logic [31:0] mem_word,
  output logic [7:0]  tx_data,
  output logic        last
);

  ubml_pkg::cmd_t cmd;
  ubml_pkg::cmd_t head;
  logic cmd_push;
  logic q_empty, q_full, q_pop;
  logic out_valid;
  logic accept;

  assign full   = q_full;
  assign empty  = !out_valid;
  assign accept = push && !q_full;

  ubml_front #(
    .WORDS_PER_BATCH(WORDS_PER_BATCH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  ubml_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .pop       (q_pop),
    .head      (head),
    .q_empty   (q_empty),
    .q_full    (q_full)
  );

  ubml_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .out_valid   (out_valid),
    .kind        (kind),
    .mem_address (mem_address),
    .mem_word    (mem_word),
    .tx_data     (tx_data),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_tx_no_write_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == ubml_pkg::KIND_TX) |-> (mem_address == 32'd0 && mem_word == 32'd0))
    else $error("transmit item carries write fields");

  a_write_no_tx: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == ubml_pkg::KIND_WRITE) |-> (tx_data == 8'd0))
    else $error("write item carries transmit byte");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("word completed with command queue full");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result present after reset");
`endif

endmodule

### sim/tb_uart_batch_memory_loader.sv
// Testbench for uart_batch_memory_loader: feeds serial bytes, predicts memory writes and
// checksum bytes with its own loader model, and checks every popped result in order.
// Depends on ubml_pkg and the uart_batch_memory_loader RTL.
`timescale 1ns / 100ps

module tb_uart_batch_memory_loader;

  localparam int unsigned RANDOM_BYTES = 240;

  // receiver stall styles
  localparam int unsigned POP_EVERY  = 0;
  localparam int unsigned POP_HALF   = 1;
  localparam int unsigned POP_SPARSE = 2;
  localparam int unsigned POP_BLOCKS = 3;

  typedef struct {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] word;
    logic [7:0]  tx;
    logic        last;
  } load_result_t;

  class loader_scoreboard;
    ubml_pkg::phase_t ph;
    logic [1:0]   byte_pos;
    int unsigned  words_done;
    logic [31:0]  shift_acc;
    logic [31:0]  wr_ptr;
    logic [31:0]  csum;
    load_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  writes_seen;
    int unsigned  tx_seen;
    int unsigned  batches_done;

    function new();
      ph = ubml_pkg::PH_IDLE;
      byte_pos = '0;
      words_done = 0;
      shift_acc = '0;
      wr_ptr = '0;
      csum = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void add_result(logic k, logic [31:0] a, logic [31:0] w, logic [7:0] t,
                             logic l);
      load_result_t r;
      r.kind = k;
      r.addr = a;
      r.word = w;
      r.tx = t;
      r.last = l;
      expected_q.push_back(r);
    endfunction

    // advance the loader state by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [31:0] w;
      bit          end_of_batch;
      if (ph != ubml_pkg::PH_ADDR && ph != ubml_pkg::PH_DATA) begin
        ph = ubml_pkg::PH_IDLE;
        if (b == ubml_pkg::CMD_BATCH) begin
          ph = ubml_pkg::PH_ADDR;
          byte_pos = '0;
          words_done = 0;
          shift_acc = '0;
          csum = '0;
        end
        return;
      end
      shift_acc = {shift_acc[23:0], b};
      if (byte_pos < 2'd3) begin
        byte_pos++;
        return;
      end
      byte_pos = '0;
      w = shift_acc;
      shift_acc = '0;
      if (ph == ubml_pkg::PH_ADDR) begin
        wr_ptr = w;
        words_done = 0;
        csum = '0;
        ph = ubml_pkg::PH_DATA;
        return;
      end
      csum ^= w;
      words_done++;
      end_of_batch = (words_done >= ubml_pkg::WORDS_PER_BATCH_DEF);
      add_result(ubml_pkg::KIND_WRITE, wr_ptr, w, 8'h00, !end_of_batch);
      wr_ptr += 32'd4;
      if (end_of_batch) begin
        for (int i = 0; i < 4; i++)
          add_result(ubml_pkg::KIND_TX, 32'h0, 32'h0, csum[31 - 8 * i -: 8], i == 3);
        ph = ubml_pkg::PH_IDLE;
        words_done = 0;
        batches_done++;
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic k, logic [31:0] a, logic [31:0] w, logic [7:0] t, logic l);
      load_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d addr=%h word=%h tx=%h",
                                  k, a, w, t));
        return;
      end
      e = expected_q.pop_front();
      if (k == ubml_pkg::KIND_WRITE) writes_seen++;
      else tx_seen++;
      if (k !== e.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", k, e.kind));
      if (a !== e.addr)
        report_mismatch($sformatf("mem_address %h, expected %h", a, e.addr));
      if (w !== e.word)
        report_mismatch($sformatf("mem_word %h, expected %h", w, e.word));
      if (t !== e.tx)
        report_mismatch($sformatf("tx_data %h, expected %h", t, e.tx));
      if (l !== e.last)
        report_mismatch($sformatf("last %0d, expected %0d", l, e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [31:0] mem_address;
  logic [31:0] mem_word;
  logic [7:0]  tx_data;
  logic        last;

  loader_scoreboard sb;
  int unsigned      burst_left = 0;
  int unsigned      bytes_sent = 0;
  bit               quiet_stretch = 1'b0;
  int unsigned      stall_style = POP_EVERY;
  int unsigned      style_left = 0;
  int unsigned      hold_left = 0;

  uart_batch_memory_loader dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .mem_address(mem_address),
    .mem_word(mem_word),
    .tx_data(tx_data),
    .last(last)
  );

  always #5 clk = ~clk;

  // sample both handshakes on the edge that completes them
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_byte(rx_byte);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(kind, mem_address, mem_word, tx_data, last);
  end

  // receiver: switch between stall styles every so often
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(POP_BLOCKS, POP_EVERY);
      style_left <= $urandom_range(120, 20);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      POP_EVERY:  pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(1, 0));
      POP_SPARSE: pop <= ($urandom_range(3, 0) == 0);
      default: begin
        if (hold_left == 0) begin
          pop <= 1'b1;
          hold_left <= $urandom_range(25, 0);
        end else begin
          pop <= 1'b0;
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = quiet_stretch ? 0 : $urandom_range(6, 0);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[31 - 8 * i -: 8]);
  endtask

  // hold the sender until every predicted result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7, 0))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31, 0);
      3: return {4{ubml_pkg::CMD_BATCH}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(3, 0))
      0: return 32'hFFFF_FFF0 + $urandom_range(15, 0);
      1: return $urandom_range(64, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_batch(input int unsigned n_words);
    send_byte(ubml_pkg::CMD_BATCH);
    send_word(pick_addr());
    for (int i = 0; i < n_words; i++) send_word(pick_word());
  endtask

  initial begin
    logic [31:0] corner_words [16];
    int unsigned r;
    sb = new();
    corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                     32'h4242_4242, 32'h0000_00FF, 32'hFF00_0000, 32'hA5A5_A5A5,
                     32'h5A5A_5A5A, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678,
                     32'h8765_4321, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'h0000_0042};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle noise, a near-miss of the command, then an unaligned batch that wraps
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'hC2);
    send_byte(ubml_pkg::CMD_BATCH);
    send_word(32'hFFFF_FFF6);
    foreach (corner_words[i]) send_word(corner_words[i]);
    wait_drained();

    // repeated command byte becomes the first address byte
    send_byte(ubml_pkg::CMD_BATCH);
    send_byte(ubml_pkg::CMD_BATCH);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h10);
    for (int i = 0; i < ubml_pkg::WORDS_PER_BATCH_DEF; i++) send_word(pick_word());

    r = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < r) begin
      quiet_stretch = ($urandom_range(3, 0) == 0);
      case ($urandom_range(9, 0))
        0: repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)));
        1: send_random_batch($urandom_range(ubml_pkg::WORDS_PER_BATCH_DEF - 1, 0));
        default: send_random_batch(ubml_pkg::WORDS_PER_BATCH_DEF);
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d bytes in, %0d memory writes and %0d checksum bytes out",
             bytes_sent, sb.writes_seen, sb.tx_seen);
    $display("%0d batches completed, %0d mismatches", sb.batches_done, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("tb: failure");
    $finish;
  end

endmodule
